// ===== hdl/pale_pkg.sv =====
// Shared types and codes for the positional array list engine.
// Used by the controller, the datapath and the top level; no dependencies.
package pale_pkg;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the input word
    logic eval;    // check range, set up the walk
    logic step;    // issue one store read, advance the walk index
    logic commit;  // apply the list update
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_walk;
    logic at_last;
    logic hit;
  } dp_stat_t;

endpackage

// ===== hdl/pale_ctrl.sv =====
// Controller state machine for the positional array list engine.
// Depends on pale_pkg; drives pale_dpath through ctl_cmd_t.
module pale_ctrl import pale_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_WALK   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_COMMIT = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.eval   = 1'b1;
        state_next = stat.need_walk ? S_WALK : S_COMMIT;
      end
      S_WALK: begin
        // stop early once locate has its first match
        if (stat.hit) begin
          state_next = S_DRAIN;
        end else begin
          cmd.step = 1'b1;
          if (stat.at_last) begin
            state_next = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = !((state == S_IDLE) || (state == S_DONE));
  assign done = (state == S_DONE);

endmodule

// ===== hdl/pale_dpath.sv =====
// Datapath for the positional array list engine: element store, length,
// walk index and result registers. Depends on pale_pkg; driven by pale_ctrl.
module pale_dpath import pale_pkg::*; #(
  parameter int CAPACITY      = 128,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output dp_stat_t           stat,
  input  logic [2:0]         operation,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               error,
  output logic signed [31:0] element_out,
  output logic [7:0]         found_position,
  output logic [7:0]         list_length,
  output logic               list_empty
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int EW   = ELEMENT_WIDTH;

  logic [EW-1:0] mem [CAPACITY];

  logic [2:0]           op_q;
  logic [7:0]           pos_q;
  logic [EW-1:0]        val_q;
  logic [CW-1:0]        count;
  logic [AW-1:0]        idx;
  logic [AW-1:0]        last_q;
  logic                 down_q;
  logic                 rd_v;
  logic [AW-1:0]        rd_idx;
  logic [EW-1:0]        rdata;
  logic signed [EW-1:0] elem_q;
  logic [CW-1:0]        found_q;
  logic                 err_q;

  logic [CMPW-1:0] pos_w, n_w, pos_m1, n_m1;
  logic            err_c, need_c, down_c;
  logic [AW-1:0]   start_c, last_c;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [EW-1:0]   wdata;

  assign pos_w  = CMPW'(pos_q);
  assign n_w    = CMPW'(count);
  assign pos_m1 = pos_w - CMPW'(1);
  assign n_m1   = n_w - CMPW'(1);

  // range check and walk bounds
  always_comb begin
    err_c   = 1'b0;
    need_c  = 1'b0;
    down_c  = 1'b0;
    start_c = pos_m1[AW-1:0];
    last_c  = n_m1[AW-1:0];
    case (op_q)
      OP_INSERT: begin
        err_c   = (pos_w == '0) || (pos_w > n_w + CMPW'(1)) ||
                  (n_w >= CMPW'(CAPACITY));
        need_c  = !err_c && (pos_w <= n_w);
        down_c  = 1'b1;
        start_c = n_m1[AW-1:0];
        last_c  = pos_m1[AW-1:0];
      end
      OP_DELETE: begin
        err_c  = (pos_w == '0) || (pos_w > n_w);
        need_c = !err_c;
      end
      OP_GET: begin
        err_c  = (pos_w == '0) || (pos_w > n_w);
        need_c = !err_c;
        last_c = pos_m1[AW-1:0];
      end
      OP_LOCATE: begin
        need_c  = (count != '0);
        start_c = '0;
      end
      OP_CLEAR: begin
        need_c = 1'b0;
      end
      default: begin
        err_c = 1'b1;
      end
    endcase
  end

  assign stat.need_walk = need_c;
  assign stat.at_last   = (idx == last_q);
  assign stat.hit       = (found_q != '0);

  // store write port: shifted entries while walking, new element at commit
  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = rdata;
    if (rd_v && (op_q == OP_INSERT)) begin
      we    = 1'b1;
      waddr = rd_idx + AW'(1);
    end else if (rd_v && (op_q == OP_DELETE) && (rd_idx != pos_m1[AW-1:0])) begin
      we    = 1'b1;
      waddr = rd_idx - AW'(1);
    end else if (cmd.commit && !err_q && (op_q == OP_INSERT)) begin
      we    = 1'b1;
      waddr = pos_m1[AW-1:0];
      wdata = val_q;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata  <= mem[idx];
    rd_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rd_v  <= 1'b0;
    end else begin
      rd_v <= cmd.step;
      if (cmd.commit && !err_q) begin
        case (op_q)
          OP_INSERT: count <= count + CW'(1);
          OP_DELETE: count <= count - CW'(1);
          OP_CLEAR:  count <= '0;
          default:   count <= count;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= operation;
      pos_q   <= position;
      val_q   <= EW'(value);
      elem_q  <= '0;
      found_q <= '0;
    end
    if (cmd.eval) begin
      err_q  <= err_c;
      idx    <= start_c;
      last_q <= last_c;
      down_q <= down_c;
    end
    if (cmd.step) begin
      idx <= down_q ? idx - AW'(1) : idx + AW'(1);
    end
    if (rd_v) begin
      case (op_q)
        OP_DELETE: begin
          if (rd_idx == pos_m1[AW-1:0]) begin
            elem_q <= rdata;
          end
        end
        OP_GET: begin
          elem_q <= rdata;
        end
        OP_LOCATE: begin
          // keep only the first match
          if ((found_q == '0) && (rdata == val_q)) begin
            found_q <= CW'(rd_idx) + CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign error          = err_q;
  assign element_out    = 32'(elem_q);
  assign found_position = 8'(found_q);
  assign list_length    = 8'(count);
  assign list_empty     = (count == '0);

endmodule

// ===== hdl/positional_array_list_engine_unit.sv =====
// Positional array list engine. A word passes through the decode, commit and done states;
// words with a store walk (all but clear, refused words, insert at the tail and locate on
// an empty list) also pass through the walk and drain states: get reads one entry, insert
// and delete read count - position + 1 entries, locate reads until its first match or the end.
// The engine takes no new word while busy; the next word is taken in the result cycle.
// Synchronous active-high reset empties the list; store contents stay unset.
module positional_array_list_engine_unit import pale_pkg::*; #(
  parameter int CAPACITY      = 128,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         operation,
  input  logic [7:0]         position,
  input  logic signed [31:0] value,
  output logic               error,
  output logic signed [31:0] element_out,
  output logic [7:0]         found_position,
  output logic [7:0]         list_length,
  output logic               list_empty
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  pale_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pale_dpath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .operation      (operation),
    .position       (position),
    .value          (value),
    .error          (error),
    .element_out    (element_out),
    .found_position (found_position),
    .list_length    (list_length),
    .list_empty     (list_empty)
  );

endmodule

// ===== hdl/pale_chk.sv =====
// Port-level checks for the positional array list engine, bound to the top
// level. Depends only on the top level's ports.
module pale_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic               error,
  input logic signed [31:0] element_out,
  input logic [7:0]         found_position
);

  // a result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst !== 1'b0)
    done |=> !done) else $error("done held for two cycles");

  a_busy_done: assert property (@(posedge clk) disable iff (rst !== 1'b0)
    !(busy && done)) else $error("busy during result cycle");

  // an accepted word keeps the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst !== 1'b0)
    (start && !busy) |=> busy) else $error("accepted word not taken up");

  // a refused word carries no element and no match
  a_err_zero: assert property (@(posedge clk) disable iff (rst !== 1'b0)
    (done && error) |-> ((element_out == 32'sd0) && (found_position == 8'd0)))
    else $error("refused word returned data");

endmodule

bind positional_array_list_engine_unit pale_chk u_pale_chk (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for the positional array list engine: a directed table, then random
// segments of all operations, every result checked against typed-in values or a list model.
// Depends on pale_pkg and positional_array_list_engine_unit from the hdl folder.
module tb_top import pale_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_CAP      = 128;
  localparam int ELEM_W        = 32;
  localparam int RANDOM_ITEMS  = 1100;
  localparam int DRAIN_CYCLES  = LIST_CAP + 16;
  localparam int QUIET_FIRST   = 400;
  localparam int QUIET_LAST    = 700;
  localparam int SETTLE_POINT  = 550;

  // codes outside the operation set
  localparam logic [2:0] OP_BAD_FIRST = 3'd5;
  localparam logic [2:0] OP_BAD_LAST  = 3'd7;

  typedef struct packed {
    logic        error;
    logic [31:0] element;
    logic [7:0]  found;
    logic [7:0]  length;
    logic        empty;
  } list_result_t;

  typedef struct {
    logic [2:0]   op;
    logic [7:0]   pos;
    logic [31:0]  val;
    bit           fixed;
    list_result_t want;
  } stim_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} seg_mode_t;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic              done;
  logic [2:0]        operation;
  logic [7:0]        position;
  logic signed [31:0] value;
  logic              error;
  logic signed [31:0] element_out;
  logic [7:0]        found_position;
  logic [7:0]        list_length;
  logic              list_empty;

  logic [ELEM_W-1:0] list_model_store [LIST_CAP];
  int                list_model_count;
  list_result_t      pending_results [$];
  stim_row_t         directed_rows [$];
  int                fail_count;

  positional_array_list_engine_unit #(
    .CAPACITY      (LIST_CAP),
    .ELEMENT_WIDTH (ELEM_W)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .done           (done),
    .operation      (operation),
    .position       (position),
    .value          (value),
    .error          (error),
    .element_out    (element_out),
    .found_position (found_position),
    .list_length    (list_length),
    .list_empty     (list_empty)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Apply one word to the list model and return the result it must give.
  function automatic list_result_t apply_list_op(logic [2:0] op, logic [7:0] pos,
                                                 logic [31:0] val);
    list_result_t r;
    int p;
    p = int'(pos);
    r = '0;
    case (op)
      OP_INSERT: begin
        if (p < 1 || p > list_model_count + 1 || list_model_count >= LIST_CAP) begin
          r.error = 1'b1;
        end else begin
          for (int j = list_model_count; j >= p; j--)
            list_model_store[j] = list_model_store[j-1];
          list_model_store[p-1] = val[ELEM_W-1:0];
          list_model_count++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > list_model_count) begin
          r.error = 1'b1;
        end else begin
          r.element = list_model_store[p-1];
          for (int j = p; j < list_model_count; j++)
            list_model_store[j-1] = list_model_store[j];
          list_model_count--;
        end
      end
      OP_GET: begin
        if (p < 1 || p > list_model_count)
          r.error = 1'b1;
        else
          r.element = list_model_store[p-1];
      end
      OP_LOCATE: begin
        for (int j = 0; j < list_model_count; j++) begin
          if (list_model_store[j] == val[ELEM_W-1:0]) begin
            r.found = 8'(j + 1);
            break;
          end
        end
      end
      OP_CLEAR: begin
        list_model_count = 0;
      end
      default: begin
        r.error = 1'b1;
      end
    endcase
    r.length = 8'(list_model_count);
    r.empty  = (list_model_count == 0);
    return r;
  endfunction

  task automatic flag_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic add_row(logic [2:0] op, logic [7:0] pos, logic [31:0] val, bit fixed,
                         logic err, logic [31:0] elem, logic [7:0] found,
                         logic [7:0] len);
    stim_row_t row;
    row.op         = op;
    row.pos        = pos;
    row.val        = val;
    row.fixed      = fixed;
    row.want.error   = err;
    row.want.element = elem;
    row.want.found   = found;
    row.want.length  = len;
    row.want.empty   = (len == 8'd0);
    directed_rows.push_back(row);
  endtask

  // Present one word, hold it until taken, then log what it must produce.
  task automatic send_word(logic [2:0] op, logic [7:0] pos, logic [31:0] val, bit fixed,
                           list_result_t want, bit may_idle);
    list_result_t predicted;
    int gap;
    if (may_idle && $urandom_range(0, 99) < 10) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start     <= 1'b1;
    operation <= op;
    position  <= pos;
    value     <= val;
    do @(posedge clk); while (busy);
    predicted = apply_list_op(op, pos, val);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  always @(posedge clk) begin
    list_result_t want_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", element_out, 32'd0);
      end else begin
        want_r = pending_results.pop_front();
        if (error !== want_r.error)
          flag_mismatch("error", 32'(error), 32'(want_r.error));
        if (element_out !== want_r.element)
          flag_mismatch("element_out", element_out, want_r.element);
        if (found_position !== want_r.found)
          flag_mismatch("found_position", 32'(found_position), 32'(want_r.found));
        if (list_length !== want_r.length)
          flag_mismatch("list_length", 32'(list_length), 32'(want_r.length));
        if (list_empty !== want_r.empty)
          flag_mismatch("list_empty", 32'(list_empty), 32'(want_r.empty));
      end
    end
  end

  initial begin
    seg_mode_t   mode;
    int          seg_len;
    int          sent;
    int          r;
    int          t_ins, t_del, t_get, t_loc, t_clr;
    logic [2:0]  op;
    logic [7:0]  pos;
    logic [31:0] val;

    fail_count       = 0;
    list_model_count = 0;
    sent             = 0;
    rst       <= 1'b1;
    start     <= 1'b0;
    operation <= OP_CLEAR;
    position  <= 8'd0;
    value     <= 32'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // op, position, value, typed-in expectation, error, element, found, length
    add_row(OP_GET,       8'd1,   32'd0,         1, 1, 32'd0,         8'd0, 8'd0);
    add_row(OP_DELETE,    8'd1,   32'd0,         1, 1, 32'd0,         8'd0, 8'd0);
    add_row(OP_INSERT,    8'd0,   32'd5,         1, 1, 32'd0,         8'd0, 8'd0);
    add_row(OP_INSERT,    8'd2,   32'd5,         1, 1, 32'd0,         8'd0, 8'd0);
    add_row(OP_LOCATE,    8'd0,   32'd7,         1, 0, 32'd0,         8'd0, 8'd0);
    add_row(OP_INSERT,    8'd1,   32'h7FFF_FFFF, 1, 0, 32'd0,         8'd0, 8'd1);
    add_row(OP_INSERT,    8'd1,   32'h8000_0000, 1, 0, 32'd0,         8'd0, 8'd2);
    add_row(OP_INSERT,    8'd3,   32'hFFFF_FFFF, 1, 0, 32'd0,         8'd0, 8'd3);
    add_row(OP_INSERT,    8'd2,   32'd0,         1, 0, 32'd0,         8'd0, 8'd4);
    add_row(OP_GET,       8'd1,   32'd0,         1, 0, 32'h8000_0000, 8'd0, 8'd4);
    add_row(OP_GET,       8'd4,   32'd0,         1, 0, 32'hFFFF_FFFF, 8'd0, 8'd4);
    add_row(OP_GET,       8'd5,   32'd0,         1, 1, 32'd0,         8'd0, 8'd4);
    add_row(OP_GET,       8'd255, 32'd0,         1, 1, 32'd0,         8'd0, 8'd4);
    add_row(OP_LOCATE,    8'd9,   32'h7FFF_FFFF, 1, 0, 32'd0,         8'd3, 8'd4);
    add_row(OP_LOCATE,    8'd0,   32'd12345,     1, 0, 32'd0,         8'd0, 8'd4);
    add_row(OP_INSERT,    8'd5,   32'd0,         0, 0, 32'd0,         8'd0, 8'd0);
    add_row(OP_LOCATE,    8'd255, 32'd0,         1, 0, 32'd0,         8'd2, 8'd5);
    add_row(OP_BAD_FIRST, 8'd1,   32'd1,         1, 1, 32'd0,         8'd0, 8'd5);
    add_row(OP_BAD_LAST,  8'd1,   32'd1,         1, 1, 32'd0,         8'd0, 8'd5);
    add_row(OP_DELETE,    8'd1,   32'd0,         1, 0, 32'h8000_0000, 8'd0, 8'd4);
    add_row(OP_DELETE,    8'd4,   32'd0,         1, 0, 32'd0,         8'd0, 8'd3);
    add_row(OP_DELETE,    8'd0,   32'd0,         1, 1, 32'd0,         8'd0, 8'd3);
    add_row(OP_CLEAR,     8'd200, 32'd0,         1, 0, 32'd0,         8'd0, 8'd0);
    add_row(OP_LOCATE,    8'd0,   32'd0,         1, 0, 32'd0,         8'd0, 8'd0);
    add_row(OP_INSERT,    8'd1,   32'h0000_00FF, 0, 0, 32'd0,         8'd0, 8'd0);

    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                directed_rows[i].fixed, directed_rows[i].want, 1'b1);

    // hold off until the list has answered every word so far
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // the first segment fills the list to capacity and beyond
    for (int seg = 0; sent < RANDOM_ITEMS; seg++) begin
      mode    = (seg == 0) ? MODE_FILL : seg_mode_t'($urandom_range(0, 2));
      seg_len = (seg == 0) ? 240 : $urandom_range(30, 120);
      case (mode)
        MODE_FILL: begin
          t_ins = 78; t_del = 81; t_get = 89; t_loc = 98; t_clr = 98;
        end
        MODE_DRAIN: begin
          t_ins = 15; t_del = 75; t_get = 85; t_loc = 95; t_clr = 97;
        end
        default: begin
          t_ins = 35; t_del = 60; t_get = 75; t_loc = 93; t_clr = 96;
        end
      endcase
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < t_ins)      op = OP_INSERT;
        else if (r < t_del) op = OP_DELETE;
        else if (r < t_get) op = OP_GET;
        else if (r < t_loc) op = OP_LOCATE;
        else if (r < t_clr) op = OP_CLEAR;
        else                op = 3'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));

        if ($urandom_range(0, 99) < 85) begin
          if (op == OP_INSERT)
            pos = 8'($urandom_range(1, list_model_count + 1));
          else if ((op == OP_DELETE || op == OP_GET) && list_model_count > 0)
            pos = 8'($urandom_range(1, list_model_count));
          else
            pos = 8'($urandom_range(0, 255));
        end else begin
          pos = 8'($urandom_range(0, 255));
        end

        r = $urandom_range(0, 99);
        if (op == OP_LOCATE && list_model_count > 0 && r < 60)
          val = list_model_store[$urandom_range(0, list_model_count - 1)];
        else if (r < 25)
          val = 32'($urandom_range(0, 7)) - 32'd4;  // small pool, so duplicates occur
        else if (r < 35)
          case ($urandom_range(0, 3))
            0:       val = 32'h8000_0000;
            1:       val = 32'h7FFF_FFFF;
            2:       val = 32'd0;
            default: val = 32'hFFFF_FFFF;
          endcase
        else
          val = $urandom;

        if (sent == SETTLE_POINT) begin
          start <= 1'b0;
          while (pending_results.size() != 0) @(posedge clk);
        end
        send_word(op, pos, val, 1'b0, '0, !(sent >= QUIET_FIRST && sent < QUIET_LAST));
        sent++;
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
